// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/core/wbgs_pkg.sv
`timescale 1ns / 1ps
package wbgs_pkg;

   localparam int GainW  = 16;
   localparam int StepW  = 12;
   localparam int TolW   = 8;
   localparam int TriesW = 7;
   localparam int PixW   = 8;
   localparam int StatW  = 3;
   localparam int CsrAW  = 3;
   localparam int CsrDW  = 16;

   // status codes
   localparam logic [StatW-1:0] ST_ADJUST    = 3'd0;
   localparam logic [StatW-1:0] ST_CONVERGED = 3'd1;
   localparam logic [StatW-1:0] ST_RANGE     = 3'd2;
   localparam logic [StatW-1:0] ST_EXHAUSTED = 3'd3;
   localparam logic [StatW-1:0] ST_IDLE      = 3'd4;

   // register indexes
   localparam logic [CsrAW-1:0] REG_START_RED  = 3'd0;
   localparam logic [CsrAW-1:0] REG_START_BLUE = 3'd1;
   localparam logic [CsrAW-1:0] REG_TOLERANCE  = 3'd2;
   localparam logic [CsrAW-1:0] REG_START_STEP = 3'd3;
   localparam logic [CsrAW-1:0] REG_TRY_LIMIT  = 3'd4;
   localparam logic [CsrAW-1:0] REG_GAIN_FLOOR = 3'd5;
   localparam logic [CsrAW-1:0] REG_GAIN_CEIL  = 3'd6;

   // register reset values
   localparam logic [GainW-1:0]  RST_START_GAIN = 16'd32768;
   localparam logic [TolW-1:0]   RST_TOLERANCE  = 8'd3;
   localparam logic [StepW-1:0]  RST_START_STEP = 12'd1024;
   localparam logic [TriesW-1:0] RST_TRY_LIMIT  = 7'd64;
   localparam logic [GainW-1:0]  RST_GAIN_FLOOR = 16'(81 * 256);
   localparam logic [GainW-1:0]  RST_GAIN_CEIL  = 16'(226 * 256);

   typedef struct packed {
      logic [GainW-1:0]  start_red_gain;
      logic [GainW-1:0]  start_blue_gain;
      logic [TolW-1:0]   tolerance;
      logic [StepW-1:0]  start_step;
      logic [TriesW-1:0] try_limit;
      logic [GainW-1:0]  gain_floor;
      logic [GainW-1:0]  gain_ceiling;
   } cfg_type;

   typedef struct packed {
      logic signed [GainW+1:0] gain;
      logic [StepW-1:0]        step;
      logic                    dir_neg;
      logic                    settled;
   } chan_res_type;

endpackage

// File: rtl/core/wbgs_csr.sv
`timescale 1ns / 1ps
module wbgs_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [wbgs_pkg::CsrAW-1:0]  csr_addr,
   input  logic [wbgs_pkg::CsrDW-1:0]  csr_wdata,
   output wbgs_pkg::cfg_type           cfg
);

   wbgs_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_red_gain  <= wbgs_pkg::RST_START_GAIN;
         cfg_ff.start_blue_gain <= wbgs_pkg::RST_START_GAIN;
         cfg_ff.tolerance       <= wbgs_pkg::RST_TOLERANCE;
         cfg_ff.start_step      <= wbgs_pkg::RST_START_STEP;
         cfg_ff.try_limit       <= wbgs_pkg::RST_TRY_LIMIT;
         cfg_ff.gain_floor      <= wbgs_pkg::RST_GAIN_FLOOR;
         cfg_ff.gain_ceiling    <= wbgs_pkg::RST_GAIN_CEIL;
      end else if (csr_we) begin
         case (csr_addr)
            wbgs_pkg::REG_START_RED:  cfg_ff.start_red_gain  <= csr_wdata;
            wbgs_pkg::REG_START_BLUE: cfg_ff.start_blue_gain <= csr_wdata;
            wbgs_pkg::REG_TOLERANCE:  cfg_ff.tolerance  <= csr_wdata[wbgs_pkg::TolW-1:0];
            wbgs_pkg::REG_START_STEP: cfg_ff.start_step <= csr_wdata[wbgs_pkg::StepW-1:0];
            wbgs_pkg::REG_TRY_LIMIT:  cfg_ff.try_limit  <= csr_wdata[wbgs_pkg::TriesW-1:0];
            wbgs_pkg::REG_GAIN_FLOOR: cfg_ff.gain_floor      <= csr_wdata;
            wbgs_pkg::REG_GAIN_CEIL:  cfg_ff.gain_ceiling    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/wbgs_chan.sv
`timescale 1ns / 1ps
module wbgs_chan (
   input  logic [wbgs_pkg::GainW-1:0]  gain,
   input  logic [wbgs_pkg::PixW-1:0]   chan,
   input  logic [wbgs_pkg::PixW-1:0]   green,
   input  logic [wbgs_pkg::StepW-1:0]  step,
   input  logic                        dir_neg,
   input  logic [wbgs_pkg::TolW-1:0]   tolerance,
   output wbgs_pkg::chan_res_type      res
);

   logic                       neg;
   logic [wbgs_pkg::PixW-1:0]  diff;
   logic signed [wbgs_pkg::GainW+1:0] gain_s;
   logic signed [wbgs_pkg::GainW+1:0] step_s;

   always_comb begin
      neg    = chan < green;
      diff   = neg ? (green - chan) : (chan - green);
      gain_s = $signed({2'b00, gain});
      step_s = $signed({{(wbgs_pkg::GainW + 2 - wbgs_pkg::StepW){1'b0}}, step});
      res.settled = diff <= tolerance;
      if (res.settled) begin
         res.gain    = gain_s;
         res.step    = step;
         res.dir_neg = dir_neg;
      end else begin
         res.gain    = neg ? (gain_s - step_s) : (gain_s + step_s);
         // reversal halves the step
         res.step    = (neg != dir_neg) ? (step >> 1) : step;
         res.dir_neg = neg;
      end
   end

endmodule

// File: rtl/core/white_balance_gain_search_unit.sv
`timescale 1ns / 1ps
// White balance gain search. Each req word carries one frame's red, green and
// blue averages (restart flag in tuser); each produces exactly one rsp word
// with the red and blue gains to apply and a status code. The unit takes one
// word per clock while the result register is free or rsp_tready is high: the
// search state updates combinationally between the input register and the
// result register, which drives rsp_tvalid.
// Registers are to be written through the csr port only while the unit is
// idle; the block itself does not enforce it. tolerance, gain_floor and
// gain_ceiling act at once, the rest at the next restart.
module white_balance_gain_search_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [23:0]                 req_tdata,  // avg_red, avg_green, avg_blue
   input  logic                        req_tuser,  // restart
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [39:0]                 rsp_tdata,  // red_gain_out, blue_gain_out, status
   input  logic                        csr_we,
   input  logic [wbgs_pkg::CsrAW-1:0]  csr_addr,
   input  logic [wbgs_pkg::CsrDW-1:0]  csr_wdata
);

   localparam int GW = wbgs_pkg::GainW;
   localparam int TW = wbgs_pkg::TriesW;

   wbgs_pkg::cfg_type      cfg;
   wbgs_pkg::chan_res_type red_res, blue_res;

   // input stage
   logic                        in_valid_ff;
   logic                        in_restart_ff;
   logic [wbgs_pkg::PixW-1:0]   in_red_ff, in_green_ff, in_blue_ff;

   // search state
   logic [GW-1:0]                 red_gain_ff, red_gain_in;
   logic [GW-1:0]                 blue_gain_ff, blue_gain_in;
   logic [wbgs_pkg::StepW-1:0]    red_step_ff, red_step_in;
   logic [wbgs_pkg::StepW-1:0]    blue_step_ff, blue_step_in;
   logic                          red_neg_ff, red_neg_in;
   logic                          blue_neg_ff, blue_neg_in;
   logic [TW-1:0]                 tries_ff, tries_in;
   logic                          running_ff, running_in;

   // result stage
   logic                          out_valid_ff;
   logic [GW-1:0]                 out_red_ff, out_blue_ff;
   logic [wbgs_pkg::StatW-1:0]    out_status_ff, status_in;

   logic advance;
   logic out_of_range;
   logic signed [GW+1:0] lo_s, hi_s;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   wbgs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wbgs_chan u_red (
      .gain      (red_gain_ff),
      .chan      (in_red_ff),
      .green     (in_green_ff),
      .step      (red_step_ff),
      .dir_neg   (red_neg_ff),
      .tolerance (cfg.tolerance),
      .res       (red_res)
   );

   wbgs_chan u_blue (
      .gain      (blue_gain_ff),
      .chan      (in_blue_ff),
      .green     (in_green_ff),
      .step      (blue_step_ff),
      .dir_neg   (blue_neg_ff),
      .tolerance (cfg.tolerance),
      .res       (blue_res)
   );

   always_comb begin
      lo_s = $signed({2'b00, cfg.gain_floor});
      hi_s = $signed({2'b00, cfg.gain_ceiling});
      out_of_range = (red_res.gain < lo_s) || (red_res.gain > hi_s) ||
                     (blue_res.gain < lo_s) || (blue_res.gain > hi_s);

      red_gain_in  = red_gain_ff;
      blue_gain_in = blue_gain_ff;
      red_step_in  = red_step_ff;
      blue_step_in = blue_step_ff;
      red_neg_in   = red_neg_ff;
      blue_neg_in  = blue_neg_ff;
      tries_in     = tries_ff;
      running_in   = running_ff;
      status_in    = wbgs_pkg::ST_IDLE;

      if (in_restart_ff) begin
         red_gain_in  = cfg.start_red_gain;
         blue_gain_in = cfg.start_blue_gain;
         red_step_in  = cfg.start_step;
         blue_step_in = cfg.start_step;
         red_neg_in   = in_red_ff < in_green_ff;
         blue_neg_in  = in_blue_ff < in_green_ff;
         tries_in     = cfg.try_limit;
         running_in   = 1'b1;
         status_in    = wbgs_pkg::ST_ADJUST;
      end else if (running_ff) begin
         if (out_of_range) begin
            status_in = wbgs_pkg::ST_RANGE;
         end else if (red_res.settled && blue_res.settled) begin
            status_in = wbgs_pkg::ST_CONVERGED;
         end else if (tries_ff <= TW'(1)) begin
            status_in = wbgs_pkg::ST_EXHAUSTED;
         end else begin
            status_in    = wbgs_pkg::ST_ADJUST;
            tries_in     = tries_ff - TW'(1);
            red_gain_in  = red_res.gain[GW-1:0];
            blue_gain_in = blue_res.gain[GW-1:0];
            red_step_in  = red_res.step;
            blue_step_in = blue_res.step;
            red_neg_in   = red_res.dir_neg;
            blue_neg_in  = blue_res.dir_neg;
         end
         if (status_in != wbgs_pkg::ST_ADJUST) begin
            tries_in   = '0;
            running_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         red_gain_ff  <= '0;
         blue_gain_ff <= '0;
         red_step_ff  <= '0;
         blue_step_ff <= '0;
         red_neg_ff   <= 1'b0;
         blue_neg_ff  <= 1'b0;
         tries_ff     <= '0;
         running_ff   <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            red_gain_ff  <= red_gain_in;
            blue_gain_ff <= blue_gain_in;
            red_step_ff  <= red_step_in;
            blue_step_ff <= blue_step_in;
            red_neg_ff   <= red_neg_in;
            blue_neg_ff  <= blue_neg_in;
            tries_ff     <= tries_in;
            running_ff   <= running_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_restart_ff <= req_tuser;
         in_red_ff     <= req_tdata[7:0];
         in_green_ff   <= req_tdata[15:8];
         in_blue_ff    <= req_tdata[23:16];
      end
      if (advance) begin
         out_red_ff    <= red_gain_in;
         out_blue_ff   <= {blue_gain_in[GW-1:1], 1'b0};
         out_status_ff <= status_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_status_ff, out_blue_ff, out_red_ff};

endmodule

// File: rtl/core/wbgs_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wbgs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // stalled word holds
   `AST_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // blue gain is always even
   `AST_IMPL(a_blue_even, clock, reset, rsp_tvalid, rsp_tdata[16] == 1'b0)
   // status code within range and padding clear
   `AST_IMPL(a_status_pad, clock, reset, rsp_tvalid, rsp_tdata[39:35] == 5'd0 && rsp_tdata[34:32] <= 3'd4)
   // no word right after reset
   `AST_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind white_balance_gain_search_unit wbgs_checker u_wbgs_checker (.*);
